// ----- sv/gwm_pkg.sv -----
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types, constants and helpers of the glob wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int REG_BYTES  = 32;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_QUES = 8'h3F;
  localparam logic [7:0] CHAR_BANG = 8'h21;

  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd4;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'b01,
    PH_SUFFIX = 2'b10
  } phase_t;

  typedef struct packed {
    logic close_carry;
    logic next_carry;
    logic step;
  } cell_link_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- sv/gwm_cell.sv -----
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: closes its active bit over stars and steps it on
// the current character, passing carries to the next position.
// ----------------------------------------------------------------------------
module gwm_cell
  import gwm_pkg::*;
(
  input  logic [7:0]  ch,
  input  logic [7:0]  seg,
  input  logic        lt,
  input  logic        le,
  input  logic        act,
  input  cell_link_t  link_in,
  output cell_link_t  link_out,
  output logic        closed,
  output logic        next
);

  logic star;
  logic hit;
  logic adv;

  assign star   = (seg == CHAR_STAR);
  assign hit    = (seg == CHAR_QUES) || (fold(seg) == fold(ch));
  assign closed = (act && le) || link_in.close_carry;
  assign adv    = link_in.step || (closed && star && lt);
  assign next   = (adv && le) || link_in.next_carry;

  assign link_out.close_carry = closed && star && lt;
  assign link_out.step        = closed && lt && !star && hit;
  assign link_out.next_carry  = next && star && lt;

endmodule

// ----- sv/gwm_chain.sv -----
// ----------------------------------------------------------------------------
// gwm_chain
// Row of position cells over one pattern segment of a given length.
// ----------------------------------------------------------------------------
module gwm_chain
  import gwm_pkg::*;
#(
  parameter int PB = 32,
  parameter int PW = 6
)
(
  input  logic [7:0]      ch,
  input  logic [PB*8-1:0] seg,
  input  logic [PW-1:0]   len,
  input  logic [PB:0]     act,
  output logic [PB:0]     closed,
  output logic [PB:0]     next
);

  cell_link_t link [PB+1];

  assign link[0] = '0;

  for (genvar k = 0; k <= PB; k++) begin : g_cell
    logic lt;
    logic le;
    assign le = (PW'(k) <= len);
    if (k < PB) begin : g_body
      assign lt = (PW'(k) < len);
      gwm_cell u_cell (
        .ch       (ch),
        .seg      (seg[k*8 +: 8]),
        .lt       (lt),
        .le       (le),
        .act      (act[k]),
        .link_in  (link[k]),
        .link_out (link[k+1]),
        .closed   (closed[k]),
        .next     (next[k])
      );
    end else begin : g_tail
      assign lt = 1'b0;
      gwm_cell u_cell (
        .ch       (ch),
        .seg      (8'h00),
        .lt       (lt),
        .le       (le),
        .act      (act[k]),
        .link_in  (link[k]),
        .link_out (),
        .closed   (closed[k]),
        .next     (next[k])
      );
    end
  end

endmodule

// ----- sv/glob_wildcard_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Streams a byte string against a configured wildcard pattern with '?', '*'
// and an optional '!' split, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
// The input channel takes one character per transaction, flagged by is_last
// at the end of a string, or an is_empty transaction that ends the string
// without a character. Every transaction that ends a string yields one
// transaction on the output channel carrying matched.
// The block accepts one input transaction per cycle while in_stall is low.
// The result is registered when the ending transaction is accepted.
// Each cycle the active positions of the pattern segment are closed over
// stars and stepped on the character by a row of position cells; the star
// carries ripple through that row within the cycle.
// The pattern is written through the configuration channel, which is always
// ready; writes take effect from the next input transaction on.
// While the output register is full and stalled, the input is stalled too.
// Reset clears the pattern and its length to zero, empties the output
// register and returns the matcher to the start of a string.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int PATTERN_BYTES = 32
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            character,
  input  logic                  is_last,
  input  logic                  is_empty,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  matched,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PB  = PATTERN_BYTES;
  localparam int PW  = $clog2(PB + 1);
  localparam int LIM = (PB < REG_BYTES) ? PB : REG_BYTES;

  logic [CFG_DATA_W-1:0] pattern_chars [4];
  logic [LEN_W-1:0]      pattern_length;
  logic [PB:0]           prefix_active;
  logic [PB:0]           suffix_active;
  phase_t                phase;

  logic [PB*8-1:0]       pat_vec;
  logic [PB*8-1:0]       suf_vec;
  logic [LEN_W-1:0]      len_clip;
  logic [PW-1:0]         len;
  logic [PW-1:0]         split;
  logic                  has_bang;
  logic [PW-1:0]         m_pre;
  logic [PW-1:0]         m_suf;
  logic [PW-1:0]         shift_bytes;
  logic [PB:0]           start_set;
  logic [PB:0]           suf_in;
  logic [PB:0]           pre_closed;
  logic [PB:0]           pre_next;
  logic [PB:0]           suf_closed;
  logic [PB:0]           suf_next;
  logic                  in_fire;
  logic                  enter_suffix;
  logic                  ends;
  logic                  result;

  logic [PB:0]           prefix_active_next;
  logic [PB:0]           suffix_active_next;
  phase_t                phase_next;

  for (genvar i = 0; i < PB; i++) begin : g_pat
    if (i < REG_BYTES) begin : g_reg
      assign pat_vec[i*8 +: 8] = pattern_chars[i >> 3][(i & 7) * 8 +: 8];
    end else begin : g_zero
      assign pat_vec[i*8 +: 8] = 8'h00;
    end
  end

  assign len_clip = (pattern_length > LEN_W'(LIM)) ? LEN_W'(LIM) : pattern_length;
  assign len      = PW'(len_clip);

  always_comb begin
    split    = len;
    has_bang = 1'b0;
    for (int i = PB - 1; i >= 0; i--) begin
      if ((PW'(i) < len) && (pat_vec[i*8 +: 8] == CHAR_BANG)) begin
        split    = PW'(i);
        has_bang = 1'b1;
      end
    end
  end

  assign m_pre       = split;
  assign m_suf       = has_bang ? (len - split - PW'(1)) : '0;
  assign shift_bytes = split + PW'(1);
  assign suf_vec     = has_bang ? (pat_vec >> {shift_bytes, 3'b000}) : pat_vec;

  assign start_set = (PB+1)'(1);
  assign suf_in    = (phase == PH_SUFFIX) ? suffix_active : start_set;

  gwm_chain #(.PB(PB), .PW(PW)) u_prefix (
    .ch     (character),
    .seg    (pat_vec),
    .len    (m_pre),
    .act    (prefix_active),
    .closed (pre_closed),
    .next   (pre_next)
  );

  gwm_chain #(.PB(PB), .PW(PW)) u_suffix (
    .ch     (character),
    .seg    (suf_vec),
    .len    (m_suf),
    .act    (suf_in),
    .closed (suf_closed),
    .next   (suf_next)
  );

  assign in_stall     = out_valid && out_stall;
  assign cfg_ready    = 1'b1;
  assign in_fire      = in_valid && !in_stall;
  assign ends         = is_empty || is_last;
  assign enter_suffix = (phase != PH_SUFFIX) && has_bang && pre_closed[m_pre];

  always_comb begin
    prefix_active_next = prefix_active;
    suffix_active_next = suffix_active;
    phase_next         = phase;
    result             = 1'b0;
    if (is_empty) begin
      unique case (phase)
        PH_SUFFIX: result = !suf_closed[m_suf];
        default:   result = !has_bang && pre_closed[m_pre];
      endcase
    end else begin
      unique case (phase)
        PH_SUFFIX: begin
          suffix_active_next = suf_next;
          result             = !suf_next[m_suf];
        end
        default: begin
          if (enter_suffix) begin
            phase_next         = PH_SUFFIX;
            suffix_active_next = suf_next;
            result             = !suf_next[m_suf];
          end else begin
            prefix_active_next = pre_next;
            result             = !has_bang && pre_next[m_pre];
          end
        end
      endcase
    end
    if (ends) begin
      prefix_active_next = start_set;
      suffix_active_next = '0;
      phase_next         = PH_PREFIX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        pattern_chars[r] <= '0;
      end
      pattern_length <= '0;
      prefix_active  <= start_set;
      suffix_active  <= '0;
      phase          <= PH_PREFIX;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHARS_0: pattern_chars[0] <= cfg_data;
          CFG_CHARS_1: pattern_chars[1] <= cfg_data;
          CFG_CHARS_2: pattern_chars[2] <= cfg_data;
          CFG_CHARS_3: pattern_chars[3] <= cfg_data;
          CFG_LENGTH:  pattern_length   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        prefix_active <= prefix_active_next;
        suffix_active <= suffix_active_next;
        phase         <= phase_next;
      end
      if (in_fire && ends) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && ends) begin
      matched <= result;
    end
  end

endmodule
